>>> hdl/csfd_pkg.sv
// Shared types, constants and microcode ROM for the caliper serial frame decoder.
package csfd_pkg;

  localparam int FRAME_BITS = 16;

  localparam int EDGE_W    = 32;
  localparam int GAP_W     = 16;
  localparam int ACC_W     = 16;
  localparam int ACC_IDX_W = $clog2(ACC_W);
  localparam int BIDX_W    = 5;
  localparam int DIGIT_W   = 4;
  localparam int CHAR_W    = 6;
  localparam int STEP_W    = 4;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [GAP_W-1:0]  GAP_RESET  = 16'd32;
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
  localparam logic              REG_GAP_THRESHOLD = 1'b0;

  localparam logic [ACC_W-1:0] K_10000 = 16'd10000;
  localparam logic [ACC_W-1:0] K_1000  = 16'd1000;
  localparam logic [ACC_W-1:0] K_100   = 16'd100;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_BIT,
    OP_FRAME,
    OP_SUB,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_BEAT,
    COND_GAP,
    COND_GE_K,
    COND_H_NZ,
    COND_T_NZ,
    COND_OUT_BUSY
  } cond_t;

  typedef enum logic [1:0] {
    SLOT_H,
    SLOT_T,
    SLOT_O
  } slot_t;

  typedef logic [STEP_W-1:0] step_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    slot_t slot;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic no_beat;
    logic gap;
    logic ge_k;
    logic h_nz;
    logic t_nz;
    logic out_busy;
  } status_t;

  localparam step_t ST_WAIT   = 4'd0;
  localparam step_t ST_BIT    = 4'd1;
  localparam step_t ST_BDONE  = 4'd2;
  localparam step_t ST_FRAME  = 4'd3;
  localparam step_t ST_SUB_H  = 4'd4;
  localparam step_t ST_SUB_T  = 4'd5;
  localparam step_t ST_SUB_O  = 4'd6;
  localparam step_t ST_TST_H  = 4'd7;
  localparam step_t ST_TST_T  = 4'd8;
  localparam step_t ST_TO_O   = 4'd9;
  localparam step_t ST_EMIT_H = 4'd10;
  localparam step_t ST_EMIT_T = 4'd11;
  localparam step_t ST_EMIT_O = 4'd12;
  localparam step_t ST_DONE   = 4'd13;

  // jump to target when cond holds, else fall through
  function automatic uword_t ucode(step_t s);
    uword_t w;
    w = '{op: OP_NOP, cond: COND_ALWAYS, slot: SLOT_H, target: ST_WAIT};
    case (s)
      ST_WAIT:   w = '{op: OP_ACCEPT, cond: COND_NO_BEAT,  slot: SLOT_H, target: ST_WAIT};
      ST_BIT:    w = '{op: OP_BIT,    cond: COND_GAP,      slot: SLOT_H, target: ST_FRAME};
      ST_BDONE:  w = '{op: OP_NOP,    cond: COND_ALWAYS,   slot: SLOT_H, target: ST_WAIT};
      ST_FRAME:  w = '{op: OP_FRAME,  cond: COND_NEVER,    slot: SLOT_H, target: ST_WAIT};
      ST_SUB_H:  w = '{op: OP_SUB,    cond: COND_GE_K,     slot: SLOT_H, target: ST_SUB_H};
      ST_SUB_T:  w = '{op: OP_SUB,    cond: COND_GE_K,     slot: SLOT_T, target: ST_SUB_T};
      ST_SUB_O:  w = '{op: OP_SUB,    cond: COND_GE_K,     slot: SLOT_O, target: ST_SUB_O};
      ST_TST_H:  w = '{op: OP_NOP,    cond: COND_H_NZ,     slot: SLOT_H, target: ST_EMIT_H};
      ST_TST_T:  w = '{op: OP_NOP,    cond: COND_T_NZ,     slot: SLOT_T, target: ST_EMIT_T};
      ST_TO_O:   w = '{op: OP_NOP,    cond: COND_ALWAYS,   slot: SLOT_O, target: ST_EMIT_O};
      ST_EMIT_H: w = '{op: OP_EMIT,   cond: COND_OUT_BUSY, slot: SLOT_H, target: ST_EMIT_H};
      ST_EMIT_T: w = '{op: OP_EMIT,   cond: COND_OUT_BUSY, slot: SLOT_T, target: ST_EMIT_T};
      ST_EMIT_O: w = '{op: OP_EMIT,   cond: COND_OUT_BUSY, slot: SLOT_O, target: ST_EMIT_O};
      ST_DONE:   w = '{op: OP_NOP,    cond: COND_ALWAYS,   slot: SLOT_O, target: ST_WAIT};
      default:   w = '{op: OP_NOP,    cond: COND_ALWAYS,   slot: SLOT_H, target: ST_WAIT};
    endcase
    return w;
  endfunction

  function automatic logic [ACC_W-1:0] k_of(slot_t s);
    logic [ACC_W-1:0] k;
    k = K_100;
    case (s)
      SLOT_H:  k = K_10000;
      SLOT_T:  k = K_1000;
      default: k = K_100;
    endcase
    return k;
  endfunction

endpackage

>>> hdl/csfd_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
module csfd_seq (
  input  logic              clk,
  input  logic              rst,
  input  csfd_pkg::status_t status,
  output csfd_pkg::uword_t  ctrl
);
  import csfd_pkg::*;

  step_t  pc;
  step_t  pc_next;
  uword_t uw;
  logic   take;

  assign uw   = ucode(pc);
  assign ctrl = uw;

  always_comb begin
    case (uw.cond)
      COND_NEVER:    take = 1'b0;
      COND_ALWAYS:   take = 1'b1;
      COND_NO_BEAT:  take = status.no_beat;
      COND_GAP:      take = status.gap;
      COND_GE_K:     take = status.ge_k;
      COND_H_NZ:     take = status.h_nz;
      COND_T_NZ:     take = status.t_nz;
      COND_OUT_BUSY: take = status.out_busy;
      default:       take = 1'b0;
    endcase
    pc_next = take ? uw.target : step_t'(pc + 1'b1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

>>> hdl/csfd_datapath.sv
// Datapath: edge timing, bit gathering, decimal digit extraction and output register.
module csfd_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  csfd_pkg::uword_t              ctrl,
  output csfd_pkg::status_t             status,
  input  logic [csfd_pkg::GAP_W-1:0]    gap_threshold,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [csfd_pkg::EDGE_W-1:0]   edge_time,
  input  logic                          data_level,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [csfd_pkg::CHAR_W-1:0]   digit_char,
  output logic                          last_digit
);
  import csfd_pkg::*;

  logic [EDGE_W-1:0]  last_edge_time;
  logic [BIDX_W-1:0]  bit_index;
  logic [ACC_W-1:0]   acc;
  logic               gap_flag;
  logic               level;
  logic [ACC_W-1:0]   rem;
  logic [DIGIT_W-1:0] dcnt;
  logic [DIGIT_W-1:0] dig_h;
  logic [DIGIT_W-1:0] dig_t;
  logic [DIGIT_W-1:0] dig_o;
  logic [DIGIT_W-1:0] dig_sel;
  logic [EDGE_W-1:0]  delta;
  logic [ACC_W-1:0]   k;
  logic               beat;
  logic               ge_k;
  logic               out_busy;

  assign in_ready = (ctrl.op == OP_ACCEPT);
  assign beat     = in_valid && in_ready;
  assign delta    = edge_time - last_edge_time;
  assign k        = k_of(ctrl.slot);
  assign ge_k     = (rem >= k);
  assign out_busy = out_valid && !out_ready;

  always_comb begin
    case (ctrl.slot)
      SLOT_H:  dig_sel = dig_h;
      SLOT_T:  dig_sel = dig_t;
      default: dig_sel = dig_o;
    endcase
  end

  assign status = '{no_beat: !in_valid, gap: gap_flag, ge_k: ge_k,
                    h_nz: (dig_h != '0), t_nz: (dig_t != '0), out_busy: out_busy};

  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time <= '0;
      bit_index      <= BIDX_W'(1);
      acc            <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (beat) begin
        last_edge_time <= edge_time;
      end
      if (ctrl.op == OP_BIT && !gap_flag && bit_index < BIDX_W'(FRAME_BITS)) begin
        if (!level && bit_index < BIDX_W'(ACC_W)) begin
          acc[bit_index[ACC_IDX_W-1:0]] <= 1'b1;
        end
        bit_index <= bit_index + 1'b1;
      end
      if (ctrl.op == OP_FRAME) begin
        acc       <= '0;
        bit_index <= '0;
      end
      if (ctrl.op == OP_EMIT && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (beat) begin
      gap_flag <= (delta > EDGE_W'(gap_threshold));
      level    <= data_level;
    end
    if (ctrl.op == OP_FRAME) begin
      rem  <= acc;
      dcnt <= '0;
    end
    if (ctrl.op == OP_SUB) begin
      if (ge_k) begin
        rem  <= rem - k;
        dcnt <= dcnt + 1'b1;
      end else begin
        dcnt <= '0;
        case (ctrl.slot)
          SLOT_H:  dig_h <= dcnt;
          SLOT_T:  dig_t <= dcnt;
          default: dig_o <= dcnt;
        endcase
      end
    end
    if (ctrl.op == OP_EMIT && !out_busy) begin
      digit_char <= ASCII_ZERO + CHAR_W'(dig_sel);
      last_digit <= (ctrl.slot == SLOT_O);
    end
  end

endmodule

>>> hdl/caliper_serial_frame_decoder_top.sv
// Top level of the caliper serial frame decoder: register port, sequencer and datapath.
//
//  channel  direction  handshake             payload
//  in       sink       in_valid / in_ready   edge_time[31:0], data_level
//  out      source     out_valid / out_ready digit_char[5:0], last_digit
//  cfg      APB slave  psel/penable/pready   paddr[2:0], pwdata, prdata (gap_threshold @ 0)
//
// An edge that does not end a frame goes through WAIT, BIT and BDONE. A frame-ending edge
// runs the digit extraction loops (one subtract of 10000, 1000 or 100 per cycle) and then
// emits 1 to 3 digits, each of which can be held by an out stall.
// The single output register lets the next edge be taken while the last digit waits.
// Reset is synchronous; the block accepts an edge in the first cycle after it.
module caliper_serial_frame_decoder_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [csfd_pkg::EDGE_W-1:0]    edge_time,
  input  logic                           data_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [csfd_pkg::CHAR_W-1:0]    digit_char,
  output logic                           last_digit,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [csfd_pkg::PADDR_W-1:0]   paddr,
  input  logic [csfd_pkg::PDATA_W-1:0]   pwdata,
  output logic [csfd_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);
  import csfd_pkg::*;

  logic [GAP_W-1:0] gap_threshold;
  uword_t           ctrl;
  status_t          status;
  logic             reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[PADDR_W-1] == REG_GAP_THRESHOLD);
  assign prdata  = reg_hit ? PDATA_W'(gap_threshold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_threshold <= GAP_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      gap_threshold <= pwdata[GAP_W-1:0];
    end
  end

  csfd_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  csfd_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctrl          (ctrl),
    .status        (status),
    .gap_threshold (gap_threshold),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .edge_time     (edge_time),
    .data_level    (data_level),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .digit_char    (digit_char),
    .last_digit    (last_digit)
  );

  a_ready_after_reset: assert property (@(posedge clk) rst |=> in_ready)
    else $error("in_ready low after reset");

  a_one_beat_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat taken while first is in work");

  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (digit_char >= ASCII_ZERO && digit_char <= ASCII_ZERO + 6'd9))
    else $error("digit_char outside 0..9");

endmodule

>>> tb/tb_caliper_serial_frame_decoder_top.sv
// Self-checking bench for the caliper frame decoder: random edge frames vs. a digit predictor.
module tb_caliper_serial_frame_decoder_top;
  import csfd_pkg::*;

  class reading_scoreboard;
    typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
    } digit_t;

    logic [GAP_W-1:0]  gap_thr;
    logic [EDGE_W-1:0] prev_time;
    logic [BIDX_W-1:0] bit_pos;
    logic [ACC_W-1:0]  acc;
    digit_t            pending[$];
    int                errors;
    int                checked;
    int                readings;

    function new();
      gap_thr   = GAP_RESET;
      prev_time = '0;
      bit_pos   = BIDX_W'(1);
      acc       = '0;
      errors    = 0;
      checked   = 0;
      readings  = 0;
    endfunction

    function void take_edge(logic [EDGE_W-1:0] t, logic lvl);
      logic [EDGE_W-1:0] elapsed;
      int unsigned       value;
      int unsigned       scale;
      elapsed = t - prev_time;
      if (elapsed > EDGE_W'(gap_thr)) begin
        value = acc / 100;
        scale = (value >= 100) ? 100 : (value >= 10) ? 10 : 1;
        while (scale > 0) begin
          pending.push_back('{ch: ASCII_ZERO + CHAR_W'((value / scale) % 10),
                              last: (scale == 1)});
          scale = scale / 10;
        end
        readings++;
        acc     = '0;
        bit_pos = '0;
      end else if (bit_pos < FRAME_BITS) begin
        if (!lvl) acc[bit_pos[ACC_IDX_W-1:0]] = 1'b1;
        bit_pos = bit_pos + 1'b1;
      end
      prev_time = t;
    endfunction

    function void check_digit(logic [CHAR_W-1:0] ch, logic last);
      digit_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected digit: expected none, actual char %0d last %0b",
                 $time, ch, last);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (ch !== want.ch) begin
        errors++;
        $display("%0t: digit_char mismatch: expected %0d, actual %0d", $time, want.ch, ch);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last_digit mismatch: expected %0b, actual %0b", $time, want.last, last);
      end
    endfunction
  endclass

  localparam logic [PADDR_W-1:0] GAP_ADDR = {REG_GAP_THRESHOLD, 2'b00};
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_EDGES   = 240;
  localparam int PHASE_EDGES    = 48;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [EDGE_W-1:0]  edge_time = '0;
  logic               data_level = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CHAR_W-1:0]  digit_char;
  logic               last_digit;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  reading_scoreboard sb = new();
  logic [EDGE_W-1:0] stamp = '0;
  logic              no_idle = 1'b0;
  int                edges_sent = 0;
  int                settings = 0;

  caliper_serial_frame_decoder_top u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .edge_time(edge_time), .data_level(data_level),
    .out_valid(out_valid), .out_ready(out_ready),
    .digit_char(digit_char), .last_digit(last_digit),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("%0t: timeout, %0d digits still expected", $time, sb.pending.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // digit sink with random backpressure
  initial begin
    int unsigned stall;
    wait (rst == 1'b0);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (out_valid !== 1'b1);
      sb.check_digit(digit_char, last_digit);
    end
  end

  task automatic send_edge(input logic [EDGE_W-1:0] t, input logic lvl);
    int unsigned pause;
    pause = no_idle ? 0 : $urandom_range(0, 7);
    if (pause != 0) begin
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid   <= 1'b1;
    edge_time  <= t;
    data_level <= lvl;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.take_edge(t, lvl);
    edges_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_gap(input logic [GAP_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= GAP_ADDR;
    pwdata  <= {{(PDATA_W-GAP_W){1'b0}}, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.gap_thr = value;
    settings++;
  endtask

  // one reading: mostly full 16-bit frames, some short/overlong or broken by a stray gap
  task automatic send_frame();
    int unsigned       len;
    logic [ACC_W-1:0]  pattern;
    logic [EDGE_W-1:0] step;
    logic [EDGE_W-1:0] thr;
    thr = EDGE_W'(sb.gap_thr);
    len = ($urandom_range(0, 9) < 6) ? FRAME_BITS : $urandom_range(0, 20);
    case ($urandom_range(0, 2))
      0:       pattern = ACC_W'($urandom_range(0, 999));
      1:       pattern = ACC_W'($urandom_range(0, 9999));
      default: pattern = ACC_W'($urandom);
    endcase
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 15) == 0) step = $urandom;
      else if ($urandom_range(0, 3) == 0) step = thr;
      else step = $urandom_range(0, thr);
      stamp = stamp + step;
      send_edge(stamp, (i < ACC_W) ? ~pattern[i] : 1'($urandom_range(0, 1)));
    end
    step = $urandom;
    if ($urandom_range(0, 3) != 0 || step <= thr) step = thr + 1 + $urandom_range(0, 3);
    stamp = stamp + step;
    send_edge(stamp, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int                phase;
    int                phase_start;
    int                directed_edges;
    logic [GAP_W-1:0]  thr;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset threshold: empty frame, gap at the threshold, full frame, overflow, wrap
    send_edge(32'd33, 1'b1);
    send_edge(32'd65, 1'b0);
    repeat (15) send_edge(32'd65, 1'b0);
    send_edge(32'd65, 1'b0);
    send_edge(32'd98, 1'b1);
    send_edge(32'hFFFF_FFF0, 1'b1);
    send_edge(32'h0000_0005, 1'b1);
    send_edge(32'h0000_0025, 1'b0);
    send_edge(32'h0000_0046, 1'b0);
    directed_edges = edges_sent;
    stamp = 32'h0000_0046;

    phase = 0;
    while (edges_sent - directed_edges < RANDOM_EDGES) begin
      settle();
      case (phase % 5)
        0:       thr = '0;
        1:       thr = '1;
        2:       thr = GAP_W'($urandom_range(1, 200));
        3:       thr = GAP_RESET;
        default: thr = GAP_W'($urandom);
      endcase
      set_gap(thr);
      no_idle = (phase % 4 == 3);
      stamp   = $urandom;
      phase_start = edges_sent;
      while (edges_sent - phase_start < PHASE_EDGES) send_frame();
      phase++;
    end
    settle();

    $display("Sent %0d caliper edges under %0d gap threshold settings.", edges_sent, settings + 1);
    $display("Closed %0d readings and compared %0d digit beats.", sb.readings, sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches, %0d digits never arrived", sb.errors, sb.pending.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/csfd_pkg.sv
hdl/csfd_seq.sv
hdl/csfd_datapath.sv
hdl/caliper_serial_frame_decoder_top.sv
tb/tb_caliper_serial_frame_decoder_top.sv
